// ===== hw/rtl/dhcpop_pkg.sv =====
// ----------------------------------------------------------------------------
// dhcpop_pkg
// Shared codes and types of the DHCP option walker: parse phases, option
// codes, stop causes and the result bundle.
// ----------------------------------------------------------------------------
package dhcpop_pkg;

  // Parse phases
  localparam logic [1:0] PH_CODE    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_VALUE   = 2'd2;
  localparam logic [1:0] PH_STOPPED = 2'd3;

  // Option codes
  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_SUBNET  = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_DNS     = 8'd6;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER  = 8'd54;
  localparam logic [7:0] OPT_END     = 8'd255;

  // Stop causes
  localparam logic [1:0] CAUSE_DATA  = 2'd0;
  localparam logic [1:0] CAUSE_END   = 2'd1;
  localparam logic [1:0] CAUSE_TRUNC = 2'd2;

  // Address options keep this many value bytes
  localparam logic [7:0] ADDR_BYTES = 8'd4;

  typedef struct packed {
    logic [7:0]  message_kind;
    logic [31:0] subnet_mask;
    logic [31:0] router_address;
    logic [31:0] dns_address;
    logic [31:0] server_address;
    logic [3:0]  seen_mask;
    logic [1:0]  stop_cause;
  } result_t;

endpackage

// ===== hw/rtl/dhcpop_walker.sv =====
// ----------------------------------------------------------------------------
// dhcpop_walker
// Per-byte option walker: holds the parse phase and the kept option values,
// and presents the values as they stand after the current byte.
// ----------------------------------------------------------------------------
module dhcpop_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output dhcpop_pkg::result_t result_o
);

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] pend_q, pend_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] subnet_q, subnet_d;
  logic [31:0] router_q, router_d;
  logic [31:0] dns_q, dns_d;
  logic [31:0] server_q, server_d;
  logic [3:0]  seen_q, seen_d;
  logic [1:0]  cause_q, cause_d;

  logic        commit;
  logic        wide;
  logic [7:0]  idx;
  logic [31:0] value;

  always_comb begin
    phase_d  = phase_q;
    code_d   = code_q;
    len_d    = len_q;
    left_d   = left_q;
    pend_d   = pend_q;
    kind_d   = kind_q;
    subnet_d = subnet_q;
    router_d = router_q;
    dns_d    = dns_q;
    server_d = server_q;
    seen_d   = seen_q;
    cause_d  = cause_q;
    commit   = 1'b0;
    idx      = len_q - left_q;

    case (phase_q)
      dhcpop_pkg::PH_CODE: begin
        if (byte_i == dhcpop_pkg::OPT_PAD) begin
          phase_d = dhcpop_pkg::PH_CODE;
        end else if (byte_i == dhcpop_pkg::OPT_END) begin
          phase_d = dhcpop_pkg::PH_STOPPED;
          cause_d = dhcpop_pkg::CAUSE_END;
        end else if (last_i) begin
          phase_d = dhcpop_pkg::PH_STOPPED;
          cause_d = dhcpop_pkg::CAUSE_TRUNC;
        end else begin
          code_d  = byte_i;
          phase_d = dhcpop_pkg::PH_LENGTH;
        end
      end
      dhcpop_pkg::PH_LENGTH: begin
        len_d  = byte_i;
        left_d = byte_i;
        pend_d = '0;
        if (byte_i == 8'd0) begin
          commit = 1'b1;
        end else if (last_i) begin
          phase_d = dhcpop_pkg::PH_STOPPED;
          cause_d = dhcpop_pkg::CAUSE_TRUNC;
        end else begin
          phase_d = dhcpop_pkg::PH_VALUE;
        end
      end
      dhcpop_pkg::PH_VALUE: begin
        if (code_q == dhcpop_pkg::OPT_MSGTYPE) begin
          if (idx == 8'd0) begin
            pend_d = {24'd0, byte_i};
          end
        end else if (idx < dhcpop_pkg::ADDR_BYTES) begin
          pend_d = {pend_q[23:0], byte_i};
        end
        left_d = left_q - 8'd1;
        if (left_d == 8'd0) begin
          commit = 1'b1;
        end else if (last_i) begin
          phase_d = dhcpop_pkg::PH_STOPPED;
          cause_d = dhcpop_pkg::CAUSE_TRUNC;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    // Store a finished option from the value collected so far
    value = pend_d;
    wide  = len_d >= dhcpop_pkg::ADDR_BYTES;
    if (commit) begin
      case (code_d)
        dhcpop_pkg::OPT_MSGTYPE: begin
          if (len_d != 8'd0) begin
            kind_d = value[7:0];
          end
        end
        dhcpop_pkg::OPT_SUBNET: begin
          if (wide) begin
            subnet_d  = value;
            seen_d[0] = 1'b1;
          end
        end
        dhcpop_pkg::OPT_ROUTER: begin
          if (wide) begin
            router_d  = value;
            seen_d[1] = 1'b1;
          end
        end
        dhcpop_pkg::OPT_DNS: begin
          if (wide) begin
            dns_d     = value;
            seen_d[2] = 1'b1;
          end
        end
        dhcpop_pkg::OPT_SERVER: begin
          if (wide) begin
            server_d  = value;
            seen_d[3] = 1'b1;
          end
        end
        default: begin
          seen_d = seen_d;
        end
      endcase
      phase_d = dhcpop_pkg::PH_CODE;
      pend_d  = '0;
    end
  end

  assign result_o.message_kind   = kind_d;
  assign result_o.subnet_mask    = subnet_d;
  assign result_o.router_address = router_d;
  assign result_o.dns_address    = dns_d;
  assign result_o.server_address = server_d;
  assign result_o.seen_mask      = seen_d;
  assign result_o.stop_cause     = cause_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dhcpop_pkg::PH_CODE;
      code_q   <= '0;
      len_q    <= '0;
      left_q   <= '0;
      pend_q   <= '0;
      kind_q   <= '0;
      subnet_q <= '0;
      router_q <= '0;
      dns_q    <= '0;
      server_q <= '0;
      seen_q   <= '0;
      cause_q  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        // Final byte: the result leaves now, start the next area clean
        phase_q  <= dhcpop_pkg::PH_CODE;
        code_q   <= '0;
        len_q    <= '0;
        left_q   <= '0;
        pend_q   <= '0;
        kind_q   <= '0;
        subnet_q <= '0;
        router_q <= '0;
        dns_q    <= '0;
        server_q <= '0;
        seen_q   <= '0;
        cause_q  <= '0;
      end else begin
        phase_q  <= phase_d;
        code_q   <= code_d;
        len_q    <= len_d;
        left_q   <= left_d;
        pend_q   <= pend_d;
        kind_q   <= kind_d;
        subnet_q <= subnet_d;
        router_q <= router_d;
        dns_q    <= dns_d;
        server_q <= server_d;
        seen_q   <= seen_d;
        cause_q  <= cause_d;
      end
    end
  end

endmodule

// ===== hw/rtl/dhcp_option_parser.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_parser
// Streaming walker over the DHCP options area; one result per area.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while no final byte waits on a stalled result.
// Path: a final byte passes through the input register, then the result register;
//   a final byte holds in the input register only while the previous result is
//   stalled.
// Reset: asynchronous, active low; clears the walker and both valid flags,
//   so the first area after reset starts from an empty option set.
module dhcp_option_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  option_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  message_kind_o,
  output logic [31:0] subnet_mask_o,
  output logic [31:0] router_address_o,
  output logic [31:0] dns_address_o,
  output logic [31:0] server_address_o,
  output logic [3:0]  seen_mask_o,
  output logic [1:0]  stop_cause_o
);

  logic                in_valid_q;
  logic [7:0]          byte_q;
  logic                last_q;
  logic                advance;
  logic                out_free;
  logic                out_valid_q;
  dhcpop_pkg::result_t walk_res;
  dhcpop_pkg::result_t res_q;

  // A byte that ends an area needs room in the result register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= option_byte_i;
      last_q <= last_byte_i;
    end
  end

  dhcpop_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .result_o (walk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= walk_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign message_kind_o   = res_q.message_kind;
  assign subnet_mask_o    = res_q.subnet_mask;
  assign router_address_o = res_q.router_address;
  assign dns_address_o    = res_q.dns_address;
  assign server_address_o = res_q.server_address;
  assign seen_mask_o      = res_q.seen_mask;
  assign stop_cause_o     = res_q.stop_cause;

  // The input register holds only when a final byte waits on a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> (last_q && out_valid_q && out_stall_i))
    else $error("input register held without a blocked result");

  // A final byte that leaves the input register always yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> out_valid_q)
    else $error("final byte produced no result transaction");

  // A delivered result carries a defined stop cause
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (stop_cause_o == dhcpop_pkg::CAUSE_DATA ||
                     stop_cause_o == dhcpop_pkg::CAUSE_END ||
                     stop_cause_o == dhcpop_pkg::CAUSE_TRUNC))
    else $error("result with undefined stop cause");

endmodule

// ===== test/dhcp_option_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhcp_option_parser_tb
// Streams DHCP option areas into the walker, one byte per transaction, under
// random input gaps and output stalls. A short table of hand-made areas runs
// first, then random areas that are mostly well formed. The table rows carry
// their own expected results; an in-bench option walker predicts each random
// area's fields, seen mask and stop cause. Every result is compared field by field.
// ----------------------------------------------------------------------------
module dhcp_option_parser_tb;

  localparam int BYTE_TARGET  = 1900;
  localparam int QUIET_TAIL   = 250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TABLE_ROWS   = 27;

  localparam int SEEN_SUBNET = 0;
  localparam int SEEN_ROUTER = 1;
  localparam int SEEN_DNS    = 2;
  localparam int SEEN_SERVER = 3;

  localparam dhcpop_pkg::result_t NO_RESULT = '0;

  typedef struct packed {
    logic [7:0]          opt_byte;
    logic                last;
    logic                pinned;
    dhcpop_pkg::result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  option_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  message_kind_o;
  logic [31:0] subnet_mask_o;
  logic [31:0] router_address_o;
  logic [31:0] dns_address_o;
  logic [31:0] server_address_o;
  logic [3:0]  seen_mask_o;
  logic [1:0]  stop_cause_o;

  // Option walker state
  logic [1:0]          walk_phase;
  logic [7:0]          walk_code;
  logic [7:0]          walk_len;
  logic [7:0]          walk_left;
  logic [31:0]         walk_value;
  dhcpop_pkg::result_t walk_kept;

  dhcpop_pkg::result_t expected_areas[$];
  dhcpop_pkg::result_t head_area;
  stim_row_t           dir_table [TABLE_ROWS];
  logic [7:0]          area_bytes[$];
  int                  fail_count;
  int                  idle_cycles;
  int                  stall_left;
  bit                  quiet;

  dhcp_option_parser u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .option_byte_i    (option_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .message_kind_o   (message_kind_o),
    .subnet_mask_o    (subnet_mask_o),
    .router_address_o (router_address_o),
    .dns_address_o    (dns_address_o),
    .server_address_o (server_address_o),
    .seen_mask_o      (seen_mask_o),
    .stop_cause_o     (stop_cause_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic dhcpop_pkg::result_t area_of(
      input logic [7:0] kind, input logic [31:0] subnet,
      input logic [31:0] router, input logic [31:0] dns,
      input logic [31:0] server, input logic [3:0] seen,
      input logic [1:0] cause);
    dhcpop_pkg::result_t r;
    r.message_kind   = kind;
    r.subnet_mask    = subnet;
    r.router_address = router;
    r.dns_address    = dns;
    r.server_address = server;
    r.seen_mask      = seen;
    r.stop_cause     = cause;
    return r;
  endfunction

  function automatic void clear_walker();
    walk_phase = dhcpop_pkg::PH_CODE;
    walk_code  = '0;
    walk_len   = '0;
    walk_left  = '0;
    walk_value = '0;
    walk_kept  = '0;
  endfunction

  function automatic void store_option();
    logic wide;
    wide = walk_len >= dhcpop_pkg::ADDR_BYTES;
    case (walk_code)
      dhcpop_pkg::OPT_MSGTYPE: if (walk_len != 8'd0) walk_kept.message_kind = walk_value[7:0];
      dhcpop_pkg::OPT_SUBNET: if (wide) begin
        walk_kept.subnet_mask = walk_value;
        walk_kept.seen_mask[SEEN_SUBNET] = 1'b1;
      end
      dhcpop_pkg::OPT_ROUTER: if (wide) begin
        walk_kept.router_address = walk_value;
        walk_kept.seen_mask[SEEN_ROUTER] = 1'b1;
      end
      dhcpop_pkg::OPT_DNS: if (wide) begin
        walk_kept.dns_address = walk_value;
        walk_kept.seen_mask[SEEN_DNS] = 1'b1;
      end
      dhcpop_pkg::OPT_SERVER: if (wide) begin
        walk_kept.server_address = walk_value;
        walk_kept.seen_mask[SEEN_SERVER] = 1'b1;
      end
      default: ;
    endcase
    walk_phase = dhcpop_pkg::PH_CODE;
    walk_value = '0;
  endfunction

  // Advance the walker by one byte; return 1 with the area's fields on the final byte.
  function automatic bit walk_byte(input logic [7:0] b, input logic last,
                                   output dhcpop_pkg::result_t area_res);
    logic [7:0] idx;
    area_res = '0;
    case (walk_phase)
      dhcpop_pkg::PH_CODE: begin
        if (b == dhcpop_pkg::OPT_END) begin
          walk_phase = dhcpop_pkg::PH_STOPPED;
          walk_kept.stop_cause = dhcpop_pkg::CAUSE_END;
        end else if (b != dhcpop_pkg::OPT_PAD) begin
          if (last) begin
            walk_phase = dhcpop_pkg::PH_STOPPED;
            walk_kept.stop_cause = dhcpop_pkg::CAUSE_TRUNC;
          end else begin
            walk_code  = b;
            walk_phase = dhcpop_pkg::PH_LENGTH;
          end
        end
      end
      dhcpop_pkg::PH_LENGTH: begin
        walk_len   = b;
        walk_left  = b;
        walk_value = '0;
        if (b == 8'd0) begin
          store_option();
        end else if (last) begin
          walk_phase = dhcpop_pkg::PH_STOPPED;
          walk_kept.stop_cause = dhcpop_pkg::CAUSE_TRUNC;
        end else begin
          walk_phase = dhcpop_pkg::PH_VALUE;
        end
      end
      dhcpop_pkg::PH_VALUE: begin
        idx = walk_len - walk_left;
        if (walk_code == dhcpop_pkg::OPT_MSGTYPE) begin
          if (idx == 8'd0) walk_value = {24'd0, b};
        end else if (idx < dhcpop_pkg::ADDR_BYTES) begin
          walk_value = {walk_value[23:0], b};
        end
        walk_left = walk_left - 8'd1;
        if (walk_left == 8'd0) begin
          store_option();
        end else if (last) begin
          walk_phase = dhcpop_pkg::PH_STOPPED;
          walk_kept.stop_cause = dhcpop_pkg::CAUSE_TRUNC;
        end
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    area_res = walk_kept;
    clear_walker();
    return 1'b1;
  endfunction

  // Drive one byte transaction, with an optional gap ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                           input dhcpop_pkg::result_t want);
    dhcpop_pkg::result_t area_res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    option_byte_i <= b;
    last_byte_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (walk_byte(b, last, area_res)) expected_areas.push_back(pinned ? want : area_res);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_areas.size() == 0) begin
        $error("result transaction with no area pending");
        fail_count++;
      end else begin
        head_area = expected_areas.pop_front();
        check_field("message_kind", head_area.message_kind, message_kind_o);
        check_field("subnet_mask", head_area.subnet_mask, subnet_mask_o);
        check_field("router_address", head_area.router_address, router_address_o);
        check_field("dns_address", head_area.dns_address, dns_address_o);
        check_field("server_address", head_area.server_address, server_address_o);
        check_field("seen_mask", head_area.seen_mask, seen_mask_o);
        check_field("stop_cause", head_area.stop_cause, stop_cause_o);
      end
    end
  end

  // Output stall in bursts, held off during the quiet tail
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0 && !quiet) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int         sent;
    int         n_opts;
    int         len;
    int         pick;
    int         cut;
    logic [7:0] code;

    in_valid_i    = 1'b0;
    option_byte_i = '0;
    last_byte_i   = 1'b0;
    quiet         = 1'b0;
    fail_count    = 0;
    clear_walker();
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    dir_table = '{
      // bare End, bare Pad, code on the final byte
      '{dhcpop_pkg::OPT_END, 1'b1, 1'b1,
        area_of(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, dhcpop_pkg::CAUSE_END)},
      '{dhcpop_pkg::OPT_PAD, 1'b1, 1'b1,
        area_of(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, dhcpop_pkg::CAUSE_DATA)},
      '{dhcpop_pkg::OPT_SUBNET, 1'b1, 1'b1,
        area_of(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, dhcpop_pkg::CAUSE_TRUNC)},
      // max message type and router, End, then an ignored final byte
      '{dhcpop_pkg::OPT_MSGTYPE, 1'b0, 1'b0, NO_RESULT},
      '{8'd1,                    1'b0, 1'b0, NO_RESULT},
      '{8'hFF,                   1'b0, 1'b0, NO_RESULT},
      '{dhcpop_pkg::OPT_ROUTER,  1'b0, 1'b0, NO_RESULT},
      '{8'd4,                    1'b0, 1'b0, NO_RESULT},
      '{8'hFF,                   1'b0, 1'b0, NO_RESULT},
      '{8'hFF,                   1'b0, 1'b0, NO_RESULT},
      '{8'hFF,                   1'b0, 1'b0, NO_RESULT},
      '{8'hFF,                   1'b0, 1'b0, NO_RESULT},
      '{dhcpop_pkg::OPT_END,     1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1,
        area_of(8'hFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'b0010, dhcpop_pkg::CAUSE_END)},
      // nonzero length on the final byte
      '{dhcpop_pkg::OPT_DNS, 1'b0, 1'b0, NO_RESULT},
      '{8'd4, 1'b1, 1'b1,
        area_of(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, dhcpop_pkg::CAUSE_TRUNC)},
      // value cut short
      '{dhcpop_pkg::OPT_SUBNET, 1'b0, 1'b0, NO_RESULT},
      '{8'd4,                   1'b0, 1'b0, NO_RESULT},
      '{8'h12,                  1'b0, 1'b0, NO_RESULT},
      '{8'h34, 1'b1, 1'b1,
        area_of(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, dhcpop_pkg::CAUSE_TRUNC)},
      // empty message type, unknown code, zero length on the final byte
      '{dhcpop_pkg::OPT_MSGTYPE, 1'b0, 1'b0, NO_RESULT},
      '{8'd0,                    1'b0, 1'b0, NO_RESULT},
      '{8'd200,                  1'b0, 1'b0, NO_RESULT},
      '{8'd1,                    1'b0, 1'b0, NO_RESULT},
      '{8'h00,                   1'b0, 1'b0, NO_RESULT},
      '{dhcpop_pkg::OPT_ROUTER,  1'b0, 1'b0, NO_RESULT},
      '{8'd0, 1'b1, 1'b1,
        area_of(8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, dhcpop_pkg::CAUSE_DATA)}
    };
    foreach (dir_table[i])
      send_byte(dir_table[i].opt_byte, dir_table[i].last, dir_table[i].pinned,
                dir_table[i].want);

    sent = 0;
    while (sent < BYTE_TARGET) begin
      area_bytes.delete();
      n_opts = $urandom_range(0, 5);
      repeat (n_opts) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) code = dhcpop_pkg::OPT_PAD;
        else if (pick < 5) code = dhcpop_pkg::OPT_MSGTYPE;
        else if (pick < 8) code = dhcpop_pkg::OPT_SUBNET;
        else if (pick < 11) code = dhcpop_pkg::OPT_ROUTER;
        else if (pick < 14) code = dhcpop_pkg::OPT_DNS;
        else if (pick < 17) code = dhcpop_pkg::OPT_SERVER;
        else code = 8'($urandom_range(1, 254));
        area_bytes.push_back(code);
        if (code != dhcpop_pkg::OPT_PAD) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            len = (code == dhcpop_pkg::OPT_MSGTYPE) ? 1 : int'(dhcpop_pkg::ADDR_BYTES);
          end else if (pick < 9) begin
            len = $urandom_range(0, 9);
          end else begin
            len = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(10, 40);
          end
          area_bytes.push_back(len[7:0]);
          repeat (len) area_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      // close the area: End with trailing bytes, run to the end, cut short, or noise
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        area_bytes.push_back(dhcpop_pkg::OPT_END);
        repeat ($urandom_range(0, 3)) area_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 7 && area_bytes.size() > 1) begin
        cut = $urandom_range(1, (area_bytes.size() - 1 < 6) ? area_bytes.size() - 1 : 6);
        repeat (cut) void'(area_bytes.pop_back());
      end else if (pick == 9) begin
        area_bytes.delete();
        repeat ($urandom_range(1, 12)) area_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (area_bytes.size() == 0) area_bytes.push_back(8'($urandom_range(0, 255)));

      if (sent >= BYTE_TARGET - QUIET_TAIL) quiet = 1'b1;
      foreach (area_bytes[k])
        send_byte(area_bytes[k], k == area_bytes.size() - 1, 1'b0, NO_RESULT);
      sent += area_bytes.size();
    end
    in_valid_i <= 1'b0;

    while (expected_areas.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
